/* rtl/core/top_score_table_sort_macros.svh */
// Assertion helpers for the score table, clocked on clock, held off in reset.
`ifndef TOP_SCORE_TABLE_SORT_MACROS_SVH
`define TOP_SCORE_TABLE_SORT_MACROS_SVH

// Same-cycle implication.
`define TSTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tsts_pkg.sv */
package tsts_pkg;

   localparam int TABLE_DEPTH_DEF = 8;
   localparam int SCORE_W         = 16;
   localparam int CHAR_W          = 8;
   localparam int RANK_W          = 3;

   typedef struct packed {
      logic [CHAR_W-1:0]  char2;
      logic [CHAR_W-1:0]  char1;
      logic [CHAR_W-1:0]  char0;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_SWAP_BEST,
      ST_SWAP_OLD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_new;      // write the incoming entry at wr_addr
      logic wr_best;     // write the pass winner at wr_addr
      logic wr_swap;     // write the displaced entry at the winner's slot
      logic scan_rd;     // read rd_addr for the max search
      logic scan_first;  // first read of a pass
      logic emit_rd;     // read rd_addr for output
      logic emit_last;   // final output read
   } cmd_type;

endpackage

/* rtl/core/top_score_table_sort.sv */
// Score table of up to TABLE_DEPTH entries kept in descending order. Pulse start
// while busy is low to record one score and name; the entry is appended, or
// replaces the lowest slot once the table is full. The table is then re-sorted
// in a single-port entry memory (one read or write per cycle) and every stored
// entry is sent out in rank order, one per cycle on rsp_valid, the last one
// flagged by rsp_last_entry. The receiver cannot stall: each result is on the
// rsp_ ports for exactly one cycle. Each selection pass reads the remaining
// slots one per cycle in a max search, then writes the winner and the displaced
// entry with two swap writes. A pass with all remaining scores zero swaps
// nothing. Store contents after reset are undefined; only written slots are read.
`include "top_score_table_sort_macros.svh"

module top_score_table_sort #(
   parameter int TABLE_DEPTH = tsts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tsts_pkg::SCORE_W-1:0]  req_new_score,
   input  logic [tsts_pkg::CHAR_W-1:0]   req_name_char0,
   input  logic [tsts_pkg::CHAR_W-1:0]   req_name_char1,
   input  logic [tsts_pkg::CHAR_W-1:0]   req_name_char2,
   output logic                          rsp_valid,
   output logic [tsts_pkg::RANK_W-1:0]   rsp_rank,
   output logic [tsts_pkg::SCORE_W-1:0]  rsp_entry_score,
   output logic [tsts_pkg::CHAR_W-1:0]   rsp_entry_char0,
   output logic [tsts_pkg::CHAR_W-1:0]   rsp_entry_char1,
   output logic [tsts_pkg::CHAR_W-1:0]   rsp_entry_char2,
   output logic                          rsp_last_entry
);

   localparam int IW = $clog2(TABLE_DEPTH);

   tsts_pkg::cmd_type cmd;
   logic [IW-1:0]     wr_addr;
   logic [IW-1:0]     rd_addr;
   logic              found;

   tsts_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .found   (found),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr)
   );

   tsts_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .wr_addr         (wr_addr),
      .rd_addr         (rd_addr),
      .found           (found),
      .req_new_score   (req_new_score),
      .req_name_char0  (req_name_char0),
      .req_name_char1  (req_name_char1),
      .req_name_char2  (req_name_char2),
      .rsp_valid       (rsp_valid),
      .rsp_rank        (rsp_rank),
      .rsp_entry_score (rsp_entry_score),
      .rsp_entry_char0 (rsp_entry_char0),
      .rsp_entry_char1 (rsp_entry_char1),
      .rsp_entry_char2 (rsp_entry_char2),
      .rsp_last_entry  (rsp_last_entry)
   );

   `TSTS_ASSERT_NOW(a_new_write_on_accept, cmd.wr_new, start && !busy, "entry written without a transfer")
   `TSTS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after a transfer")
   `TSTS_ASSERT_NEXT(a_quiet_after_last, rsp_valid && rsp_last_entry, !rsp_valid, "result after last entry")
   `TSTS_ASSERT_NEXT(a_rank_steps, rsp_valid && !rsp_last_entry, rsp_valid && (rsp_rank == tsts_pkg::RANK_W'($past(rsp_rank) + 1'b1)), "results not back to back in rank order")

endmodule

/* rtl/core/tsts_ctrl.sv */
module tsts_ctrl #(
   parameter int TABLE_DEPTH = tsts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              found,
   output tsts_pkg::cmd_type                 cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   tsts_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] last_idx;
   logic          full;
   logic          sort_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsts_pkg::ST_IDLE;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign last_idx  = IW'(count_ff - CW'(1));
   assign full      = (count_ff == CW'(TABLE_DEPTH));
   // no pass left once the next pass would start on the last slot
   assign sort_done = ((CW'(i_ff) + CW'(2)) >= count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd      = '0;
      wr_addr  = i_ff;
      rd_addr  = j_ff;
      busy     = (state_ff != tsts_pkg::ST_IDLE);

      case (state_ff)
         tsts_pkg::ST_IDLE: begin
            if (start) begin
               cmd.wr_new = 1'b1;
               if (full) begin
                  wr_addr = IW'(TABLE_DEPTH - 1);
               end else begin
                  wr_addr  = IW'(count_ff);
                  count_in = count_ff + CW'(1);
               end
               state_in = tsts_pkg::ST_SETUP;
            end
         end
         tsts_pkg::ST_SETUP: begin
            i_in = '0;
            j_in = '0;
            if (count_ff <= CW'(1)) begin
               state_in = tsts_pkg::ST_EMIT;
            end else begin
               state_in = tsts_pkg::ST_SCAN;
            end
         end
         tsts_pkg::ST_SCAN: begin
            cmd.scan_rd    = 1'b1;
            cmd.scan_first = (j_ff == i_ff);
            if (j_ff == last_idx) begin
               state_in = tsts_pkg::ST_DRAIN;
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         tsts_pkg::ST_DRAIN: begin
            state_in = tsts_pkg::ST_SWAP_BEST;
         end
         tsts_pkg::ST_SWAP_BEST, tsts_pkg::ST_SWAP_OLD: begin
            if (state_ff == tsts_pkg::ST_SWAP_BEST && found) begin
               cmd.wr_best = 1'b1;
               state_in    = tsts_pkg::ST_SWAP_OLD;
            end else begin
               cmd.wr_swap = (state_ff == tsts_pkg::ST_SWAP_OLD);
               if (sort_done) begin
                  j_in     = '0;
                  state_in = tsts_pkg::ST_EMIT;
               end else begin
                  i_in     = i_ff + IW'(1);
                  j_in     = i_ff + IW'(1);
                  state_in = tsts_pkg::ST_SCAN;
               end
            end
         end
         tsts_pkg::ST_EMIT: begin
            cmd.emit_rd   = 1'b1;
            cmd.emit_last = (j_ff == last_idx);
            if (j_ff == last_idx) begin
               state_in = tsts_pkg::ST_IDLE;
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         default: begin
            state_in = tsts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/tsts_dpath.sv */
module tsts_dpath #(
   parameter int TABLE_DEPTH = tsts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tsts_pkg::cmd_type                   cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
   input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   output logic                                found,
   input  logic [tsts_pkg::SCORE_W-1:0]        req_new_score,
   input  logic [tsts_pkg::CHAR_W-1:0]         req_name_char0,
   input  logic [tsts_pkg::CHAR_W-1:0]         req_name_char1,
   input  logic [tsts_pkg::CHAR_W-1:0]         req_name_char2,
   output logic                                rsp_valid,
   output logic [tsts_pkg::RANK_W-1:0]         rsp_rank,
   output logic [tsts_pkg::SCORE_W-1:0]        rsp_entry_score,
   output logic [tsts_pkg::CHAR_W-1:0]         rsp_entry_char0,
   output logic [tsts_pkg::CHAR_W-1:0]         rsp_entry_char1,
   output logic [tsts_pkg::CHAR_W-1:0]         rsp_entry_char2,
   output logic                                rsp_last_entry
);

   localparam int IW = $clog2(TABLE_DEPTH);

   tsts_pkg::entry_type mem [TABLE_DEPTH];
   tsts_pkg::entry_type rdata_ff;
   tsts_pkg::entry_type best_ff;
   tsts_pkg::entry_type old_ff;
   tsts_pkg::entry_type new_entry;
   tsts_pkg::entry_type wr_data;
   logic [IW-1:0]       wr_idx;
   logic                wr_en;
   logic [IW-1:0]       addr_d_ff;
   logic [IW-1:0]       at_ff;
   logic                cmp_ff;
   logic                first_ff;
   logic                emit_ff;
   logic                last_ff;
   logic                found_ff;
   logic [tsts_pkg::SCORE_W-1:0] base_score;
   logic                hit;

   assign new_entry.score = req_new_score;
   assign new_entry.char0 = req_name_char0;
   assign new_entry.char1 = req_name_char1;
   assign new_entry.char2 = req_name_char2;

   assign wr_en   = cmd.wr_new | cmd.wr_best | cmd.wr_swap;
   assign wr_idx  = cmd.wr_swap ? at_ff : wr_addr;
   assign wr_data = cmd.wr_new  ? new_entry :
                    cmd.wr_best ? best_ff : old_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd | cmd.emit_rd) begin
         rdata_ff  <= mem[rd_addr];
         addr_d_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff   <= 1'b0;
         first_ff <= 1'b0;
         emit_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         cmp_ff   <= cmd.scan_rd;
         first_ff <= cmd.scan_first;
         emit_ff  <= cmd.emit_rd;
         last_ff  <= cmd.emit_rd & cmd.emit_last;
      end
   end

   // strict greater-than against zero on the first read or while nothing won yet
   assign base_score = (first_ff || !found_ff) ? '0 : best_ff.score;
   assign hit        = (rdata_ff.score > base_score);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmp_ff) begin
         if (first_ff) begin
            found_ff <= hit;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_ff) begin
         if (first_ff) begin
            old_ff <= rdata_ff;
         end
         if (hit) begin
            best_ff <= rdata_ff;
            at_ff   <= addr_d_ff;
         end
      end
   end

   assign found           = found_ff;
   assign rsp_valid       = emit_ff;
   assign rsp_rank        = tsts_pkg::RANK_W'(addr_d_ff);
   assign rsp_entry_score = rdata_ff.score;
   assign rsp_entry_char0 = rdata_ff.char0;
   assign rsp_entry_char1 = rdata_ff.char1;
   assign rsp_entry_char2 = rdata_ff.char2;
   assign rsp_last_entry  = last_ff;

endmodule

/* sim/score_rank_checker.sv */
module score_rank_checker #(
   parameter int TABLE_DEPTH = tsts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [tsts_pkg::SCORE_W-1:0] req_new_score,
   input  logic [tsts_pkg::CHAR_W-1:0]  req_name_char0,
   input  logic [tsts_pkg::CHAR_W-1:0]  req_name_char1,
   input  logic [tsts_pkg::CHAR_W-1:0]  req_name_char2,
   input  logic                         rsp_valid,
   input  logic [tsts_pkg::RANK_W-1:0]  rsp_rank,
   input  logic [tsts_pkg::SCORE_W-1:0] rsp_entry_score,
   input  logic [tsts_pkg::CHAR_W-1:0]  rsp_entry_char0,
   input  logic [tsts_pkg::CHAR_W-1:0]  rsp_entry_char1,
   input  logic [tsts_pkg::CHAR_W-1:0]  rsp_entry_char2,
   input  logic                         rsp_last_entry,
   output int                           fail_count,
   output int                           rows_pending
);
   import tsts_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [RANK_W-1:0] rank;
      entry_type         entry;
      logic              last;
   } ranked_row_type;

   entry_type      score_table [TABLE_DEPTH];
   int             entries_held;
   ranked_row_type ranked_rows_q [$];
   int             fails;

   // Insert the new entry, re-sort descending, queue the whole table in rank order.
   function automatic void record_score(input entry_type fresh);
      int                 slot;
      int                 best_at;
      logic [SCORE_W-1:0] best;
      logic               found;
      entry_type          held;
      ranked_row_type     row;
      if (entries_held >= TABLE_DEPTH) begin
         slot = TABLE_DEPTH - 1;
      end else begin
         slot = entries_held;
         entries_held++;
      end
      score_table[slot] = fresh;
      for (int i = 0; i + 1 < entries_held; i++) begin
         // strict greater-than from zero: first slot holding the max wins,
         // and a pass over all-zero scores leaves the table alone
         best    = '0;
         best_at = 0;
         found   = 1'b0;
         for (int j = i; j < entries_held; j++) begin
            if (score_table[j].score > best) begin
               best    = score_table[j].score;
               best_at = j;
               found   = 1'b1;
            end
         end
         if (found) begin
            held                 = score_table[i];
            score_table[i]       = score_table[best_at];
            score_table[best_at] = held;
         end
      end
      for (int k = 0; k < entries_held; k++) begin
         row.rank  = k[RANK_W-1:0];
         row.entry = score_table[k];
         row.last  = (k + 1 == entries_held);
         ranked_rows_q.push_back(row);
      end
   endfunction

   always @(posedge clock) begin : watch
      ranked_row_type want;
      entry_type      fresh;
      if (reset) begin
         entries_held = 0;
         ranked_rows_q.delete();
      end else begin
         if (rsp_valid) begin
            if (ranked_rows_q.size() == 0) begin
               if (fails < REPORT_LIMIT)
                  $display("unexpected result transfer: rank %0d score %h name %h %h %h last %b",
                           rsp_rank, rsp_entry_score, rsp_entry_char0, rsp_entry_char1,
                           rsp_entry_char2, rsp_last_entry);
               fails++;
            end else begin
               want = ranked_rows_q.pop_front();
               if (rsp_rank !== want.rank || rsp_entry_score !== want.entry.score ||
                   rsp_entry_char0 !== want.entry.char0 ||
                   rsp_entry_char1 !== want.entry.char1 ||
                   rsp_entry_char2 !== want.entry.char2 || rsp_last_entry !== want.last) begin
                  if (fails < REPORT_LIMIT) begin
                     $display("mismatch: expected rank %0d score %h name %h %h %h last %b",
                              want.rank, want.entry.score, want.entry.char0,
                              want.entry.char1, want.entry.char2, want.last);
                     $display("          got      rank %0d score %h name %h %h %h last %b",
                              rsp_rank, rsp_entry_score, rsp_entry_char0, rsp_entry_char1,
                              rsp_entry_char2, rsp_last_entry);
                  end
                  fails++;
               end
            end
         end
         // results of the previous transfer are checked before this one is queued
         if (start && !busy) begin
            fresh.score = req_new_score;
            fresh.char0 = req_name_char0;
            fresh.char1 = req_name_char1;
            fresh.char2 = req_name_char2;
            record_score(fresh);
         end
      end
      fail_count   <= fails;
      rows_pending <= ranked_rows_q.size();
   end

endmodule

/* sim/testbench.sv */
module testbench;
   import tsts_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_TAIL   = 60;
   localparam int DRAIN_CYCLES = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [SCORE_W-1:0] req_new_score  = '0;
   logic [CHAR_W-1:0]  req_name_char0 = '0;
   logic [CHAR_W-1:0]  req_name_char1 = '0;
   logic [CHAR_W-1:0]  req_name_char2 = '0;
   logic               rsp_valid;
   logic [RANK_W-1:0]  rsp_rank;
   logic [SCORE_W-1:0] rsp_entry_score;
   logic [CHAR_W-1:0]  rsp_entry_char0;
   logic [CHAR_W-1:0]  rsp_entry_char1;
   logic [CHAR_W-1:0]  rsp_entry_char2;
   logic               rsp_last_entry;
   int                 fail_count;
   int                 rows_pending;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   top_score_table_sort u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_new_score  (req_new_score),
      .req_name_char0 (req_name_char0),
      .req_name_char1 (req_name_char1),
      .req_name_char2 (req_name_char2),
      .rsp_valid      (rsp_valid),
      .rsp_rank       (rsp_rank),
      .rsp_entry_score(rsp_entry_score),
      .rsp_entry_char0(rsp_entry_char0),
      .rsp_entry_char1(rsp_entry_char1),
      .rsp_entry_char2(rsp_entry_char2),
      .rsp_last_entry (rsp_last_entry)
   );

   score_rank_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_new_score  (req_new_score),
      .req_name_char0 (req_name_char0),
      .req_name_char1 (req_name_char1),
      .req_name_char2 (req_name_char2),
      .rsp_valid      (rsp_valid),
      .rsp_rank       (rsp_rank),
      .rsp_entry_score(rsp_entry_score),
      .rsp_entry_char0(rsp_entry_char0),
      .rsp_entry_char1(rsp_entry_char1),
      .rsp_entry_char2(rsp_entry_char2),
      .rsp_last_entry (rsp_last_entry),
      .fail_count     (fail_count),
      .rows_pending   (rows_pending)
   );

   // Drive one score and hold it until the transfer edge; start stays high after.
   task automatic post_score(input logic [SCORE_W-1:0] score,
                             input logic [CHAR_W-1:0] c0, c1, c2);
      start          <= 1'b1;
      req_new_score  <= score;
      req_name_char0 <= c0;
      req_name_char1 <= c1;
      req_name_char2 <= c2;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return SCORE_W'($urandom_range(0, 7));
         2: return SCORE_W'(16'hFFFF - $urandom_range(0, 3));
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // partial table, zero-only passes, ties at the top, then a full table
      post_score(16'h0000, 8'h00, 8'h00, 8'h00);
      post_score(16'h0000, 8'hFF, 8'hFF, 8'hFF);
      hold_off(3);
      post_score(16'hFFFF, "A", "B", "C");
      post_score(16'hFFFF, "X", "Y", "Z");
      post_score(16'h0001, 8'h80, 8'h01, 8'h7F);
      hold_off(1);
      post_score(16'h8000, 8'h55, 8'hAA, 8'h0F);
      post_score(16'h7FFF, 8'hF0, 8'h33, 8'hCC);
      post_score(16'h0002, 8'h01, 8'h02, 8'h04);
      post_score(16'h0000, 8'h10, 8'h20, 8'h40);
      hold_off(9);
      post_score(16'hFFFF, 8'hFE, 8'hFD, 8'hFB);
      post_score(16'h0003, 8'h08, 8'hEF, 8'hDF);
      post_score(16'h0100, 8'h7F, 8'hBF, 8'hF7);
      post_score(16'h0000, 8'h00, 8'hFF, 8'h00);
      post_score(16'h0000, 8'hFF, 8'h00, 8'hFF);
      post_score(16'hFFFF, 8'h41, 8'h42, 8'h43);
      post_score(16'h00FF, 8'h20, 8'h20, 8'h20);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 1))
            hold_off($urandom_range(1, 9));
         post_score(pick_score(), CHAR_W'($urandom_range(0, 255)),
                    CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)));
      end
      start <= 1'b0;

      do @(posedge clock); while (rows_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && rows_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tsts_pkg.sv
rtl/core/tsts_ctrl.sv
rtl/core/tsts_dpath.sv
rtl/core/top_score_table_sort.sv
sim/score_rank_checker.sv
sim/testbench.sv
